// ----- sv/sosc_pkg.sv -----
// Shared constants, types and the sine table builder for the sine oscillator.
`default_nettype none

package sosc_pkg;

	// Sine table and phase accumulator geometry.
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
	localparam int PHASE_W     = 32;
	localparam int SAMPLE_W    = 16;

	// The phase step is the product of frequency and scale shifted down by this.
	localparam int PHASE_SHIFT = 48 - PHASE_W;

	// Field widths of the streams and of the state.
	localparam int SAMPLES_W   = 13;
	localparam int TLEVEL_W    = 16;
	localparam int TFREQ_W     = 21;
	localparam int SCALE_W     = 28;
	localparam int LEVEL_W     = 32;
	localparam int LSTEP_W     = 33;
	localparam int FREQ_W      = 37;
	localparam int FSTEP_W     = 38;
	localparam int FRAC_SHIFT  = 16;
	localparam int IN_TDATA_W  = 56;

	// Limits on the incoming block description.
	localparam int BLOCK_MAX        = 4096;
	localparam int LEVEL_TARGET_MAX = 32768;
	localparam int FREQ_TARGET_MAX  = 1280000;

	// Reset value of the phase scale register.
	localparam logic [SCALE_W-1:0] PHASE_SCALE_RESET = SCALE_W'(22906492);

	// Iterative divider: magnitude width and iteration counter width.
	localparam int DIV_W     = FREQ_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// Shared multiplier operand width.
	localparam int MUL_W = 32;

	typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];

	// One table entry: Taylor series of sin up to x^11 in Q30, scaled to Q15.
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
		logic [63:0] t;
		logic [63:0] quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] one_q30;
		t       = 64'(k) * 64'd4;
		quad    = t / SINE_DEPTH;
		r       = t % SINE_DEPTH;
		one_q30 = 64'd1 << 30;
		if (quad[0]) begin
			r = 64'(SINE_DEPTH) - r;
		end
		x  = (r * 64'd1686629713) / SINE_DEPTH;
		x2 = (x * x) >> 30;
		p  = one_q30;
		p  = one_q30 - (((x2 * p) >> 30) / 64'd110);
		p  = one_q30 - (((x2 * p) >> 30) / 64'd72);
		p  = one_q30 - (((x2 * p) >> 30) / 64'd42);
		p  = one_q30 - (((x2 * p) >> 30) / 64'd20);
		p  = one_q30 - (((x2 * p) >> 30) / 64'd6);
		s  = (x * p) >> 30;
		v  = (s * 64'd32767 + (one_q30 >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		if (quad >= 64'd2) begin
			return SAMPLE_W'(-$signed(v[SAMPLE_W-1:0]));
		end
		return $signed(v[SAMPLE_W-1:0]);
	endfunction

	// Whole table, built at elaboration.
	function automatic sine_rom_t sine_rom_build();
		sine_rom_t rom;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			rom[k] = sine_entry(k);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

// ----- sv/sosc_rom.sv -----
// Full-wave sine table with a registered read port.
`default_nettype none

module sosc_rom (
	input  wire logic                                  clk,
	input  wire logic [sosc_pkg::SINE_ADDR_W-1:0]      addr,
	output logic signed [sosc_pkg::SAMPLE_W-1:0]       rd_data_q
);
	import sosc_pkg::*;

	localparam sine_rom_t SineRom = sine_rom_build();

	// Synchronous read, one entry per cycle.
	always_ff @(posedge clk) begin
		rd_data_q <= SineRom[addr];
	end

endmodule

`default_nettype wire

// ----- sv/sosc_mul.sv -----
// Shared unsigned multiplier with a registered product.
`default_nettype none

module sosc_mul (
	input  wire logic                              clk,
	input  wire logic [sosc_pkg::MUL_W-1:0]        op_a,
	input  wire logic [sosc_pkg::MUL_W-1:0]        op_b,
	output logic      [2*sosc_pkg::MUL_W-1:0]      prod_q
);
	import sosc_pkg::*;

	// One product per cycle; the sequencer picks the operands.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

`default_nettype wire

// ----- sv/sosc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp increments.
`default_nettype none

module sosc_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [sosc_pkg::DIV_W-1:0]        dividend,
	input  wire logic [sosc_pkg::SAMPLES_W-1:0]    divisor,
	output logic                                   done_q,
	output logic      [sosc_pkg::DIV_W-1:0]        quotient_q
);
	import sosc_pkg::*;

	logic                   busy_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [SAMPLES_W-1:0]   rem_q;
	logic [SAMPLES_W-1:0]   dsr_q;
	logic [SAMPLES_W:0]     trial;
	logic [SAMPLES_W:0]     diff;
	logic                   fits;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		trial = {rem_q, quotient_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = (trial >= {1'b0, dsr_q});
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quotient_q <= dividend;
			rem_q      <= '0;
			dsr_q      <= divisor;
		end else if (busy_q) begin
			quotient_q <= {quotient_q[DIV_W-2:0], fits};
			rem_q      <= fits ? diff[SAMPLES_W-1:0] : trial[SAMPLES_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- sv/sine_oscillator_ramped_gain_freq.sv -----
// Top level of the ramped sine oscillator: sequencer, state and stream ports.
`default_nettype none

// Direct digital synthesis sine oscillator whose gain and frequency ramp linearly
// over a block. Each input beat produces exactly one output sample. A beat with
// tuser set starts a block: the targets are latched and the per-sample increments
// are found by two passes, level then frequency, through a one-bit-per-cycle divider
// before the beat is worked on like any other. Each beat's sample is made by the
// update of gain and frequency, the two uses of the one shared multiplier (gain, then
// phase step) and the phase update. The input is not ready while a beat is being
// worked on; a finished sample waits in the output register while the next beat is
// taken, and a beat whose sample finds that register still full waits until it frees.
// The phase scale register may be written only while no beat is in progress.
module sine_oscillator_ramped_gain_freq (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Configuration: phase scale.
	input  wire logic                                   cfg_we,
	input  wire logic [sosc_pkg::SCALE_W-1:0]           cfg_wdata,
	// Input stream.
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// block_samples [12:0], target_level [28:13], target_frequency [49:29], zeros
	input  wire logic [sosc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	// block_start [0]
	input  wire logic                                   s_axis_tuser,
	// Output stream.
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// sample_out [15:0]
	output logic      [sosc_pkg::SAMPLE_W-1:0]          m_axis_tdata
);
	import sosc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LVL_START,
		S_LVL_WAIT,
		S_FRQ_START,
		S_FRQ_WAIT,
		S_UPDATE,
		S_MUL_AMP,
		S_MUL_PH,
		S_PHASE,
		S_OUT
	} state_t;

	state_t                        state_q;
	logic [SCALE_W-1:0]            phase_scale_q;
	logic [PHASE_W-1:0]            phase_q;
	logic [LEVEL_W-1:0]            level_q;
	logic signed [LSTEP_W-1:0]     level_step_q;
	logic [FREQ_W-1:0]             frequency_q;
	logic signed [FSTEP_W-1:0]     frequency_step_q;
	logic [SAMPLES_W-1:0]          blk_n_q;
	logic [TLEVEL_W-1:0]           tlevel_q;
	logic [TFREQ_W-1:0]            tfreq_q;
	logic [SAMPLE_W-1:0]           sample_hold_q;
	logic [SAMPLE_W-1:0]           sample_q;
	logic                          out_valid_q;

	logic                          in_beat;
	logic [SAMPLES_W-1:0]          in_n;
	logic [TLEVEL_W-1:0]           in_tl;
	logic [TFREQ_W-1:0]            in_tf;
	logic [SAMPLES_W-1:0]          n_clamped;
	logic [TLEVEL_W-1:0]           tl_clamped;
	logic [TFREQ_W-1:0]            tf_clamped;

	logic signed [LEVEL_W+1:0]     ldiff;
	logic signed [FREQ_W+1:0]      fdiff;
	logic [DIV_W-1:0]              ldiff_mag;
	logic [DIV_W-1:0]              fdiff_mag;
	logic                          div_start;
	logic [DIV_W-1:0]              div_dividend;
	logic                          div_done;
	logic [DIV_W-1:0]              div_quot;

	logic signed [LEVEL_W+1:0]     lv_sum;
	logic [LEVEL_W-1:0]            lv_next;
	logic signed [FREQ_W+1:0]      fq_sum;
	logic [FREQ_W-1:0]             fq_next;

	logic signed [SAMPLE_W-1:0]    sine_q;
	logic [SAMPLE_W-2:0]           sine_mag;
	logic [MUL_W-1:0]              mul_a;
	logic [MUL_W-1:0]              mul_b;
	logic [2*MUL_W-1:0]            mul_prod;
	logic [SAMPLE_W-1:0]           amp_mag;
	logic [SAMPLE_W-1:0]           sample_next;
	logic                          out_free;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = sample_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Unpack and limit the block description.
	always_comb begin
		in_n  = s_axis_tdata[SAMPLES_W-1:0];
		in_tl = s_axis_tdata[SAMPLES_W +: TLEVEL_W];
		in_tf = s_axis_tdata[SAMPLES_W+TLEVEL_W +: TFREQ_W];
		if (in_n == '0) begin
			n_clamped = SAMPLES_W'(1);
		end else if (in_n > SAMPLES_W'(BLOCK_MAX)) begin
			n_clamped = SAMPLES_W'(BLOCK_MAX);
		end else begin
			n_clamped = in_n;
		end
		tl_clamped = (32'(in_tl) > LEVEL_TARGET_MAX) ? TLEVEL_W'(LEVEL_TARGET_MAX) : in_tl;
		tf_clamped = (32'(in_tf) > FREQ_TARGET_MAX) ? TFREQ_W'(FREQ_TARGET_MAX) : in_tf;
	end

	// Distance from the current values to the targets, as sign and magnitude.
	always_comb begin
		ldiff = $signed({2'b00, tlevel_q, {FRAC_SHIFT{1'b0}}}) - $signed({2'b00, level_q});
		fdiff = $signed({2'b00, tfreq_q, {FRAC_SHIFT{1'b0}}}) - $signed({2'b00, frequency_q});
		ldiff_mag = ldiff[LEVEL_W+1] ? DIV_W'(-ldiff) : DIV_W'(ldiff);
		fdiff_mag = fdiff[FREQ_W+1] ? DIV_W'(-fdiff) : DIV_W'(fdiff);
		div_start    = (state_q == S_LVL_START) || (state_q == S_FRQ_START);
		div_dividend = (state_q == S_LVL_START) ? ldiff_mag : fdiff_mag;
	end

	sosc_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend   (div_dividend),
		.divisor    (blk_n_q),
		.done_q     (div_done),
		.quotient_q (div_quot)
	);

	// Saturating ramp updates of gain and frequency.
	always_comb begin
		lv_sum = $signed({2'b00, level_q}) + (LEVEL_W+2)'(level_step_q);
		if (lv_sum[LEVEL_W+1]) begin
			lv_next = '0;
		end else if (lv_sum[LEVEL_W]) begin
			lv_next = '1;
		end else begin
			lv_next = lv_sum[LEVEL_W-1:0];
		end
		fq_sum = $signed({2'b00, frequency_q}) + (FREQ_W+2)'(frequency_step_q);
		if (fq_sum[FREQ_W+1]) begin
			fq_next = '0;
		end else if (fq_sum[FREQ_W]) begin
			fq_next = '1;
		end else begin
			fq_next = fq_sum[FREQ_W-1:0];
		end
	end

	sosc_rom u_rom (
		.clk       (clk),
		.addr      (phase_q[PHASE_W-1 -: SINE_ADDR_W]),
		.rd_data_q (sine_q)
	);

	// Operand selection for the shared multiplier.
	always_comb begin
		sine_mag = sine_q[SAMPLE_W-1] ? (SAMPLE_W-1)'(-sine_q) : sine_q[SAMPLE_W-2:0];
		if (state_q == S_MUL_PH) begin
			mul_a = MUL_W'(frequency_q[FREQ_W-1:FRAC_SHIFT]);
			mul_b = MUL_W'(phase_scale_q);
		end else begin
			mul_a = MUL_W'(sine_mag);
			mul_b = MUL_W'(level_q);
		end
	end

	sosc_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (mul_prod)
	);

	// Signed, saturated sample from the gain product.
	always_comb begin
		amp_mag = mul_prod[LEVEL_W-1 +: SAMPLE_W];
		if (sine_q[SAMPLE_W-1]) begin
			if (amp_mag[SAMPLE_W-1]) begin
				sample_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
			end else begin
				sample_next = SAMPLE_W'(-amp_mag);
			end
		end else begin
			if (amp_mag[SAMPLE_W-1]) begin
				sample_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
			end else begin
				sample_next = amp_mag;
			end
		end
	end

	// Sequencer, oscillator state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			phase_scale_q    <= PHASE_SCALE_RESET;
			phase_q          <= '0;
			level_q          <= '0;
			level_step_q     <= '0;
			frequency_q      <= '0;
			frequency_step_q <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				phase_scale_q <= cfg_wdata;
			end
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= s_axis_tuser ? S_LVL_START : S_UPDATE;
					end
				end
				S_LVL_START: begin
					state_q <= S_LVL_WAIT;
				end
				S_LVL_WAIT: begin
					if (div_done) begin
						level_step_q <= ldiff[LEVEL_W+1] ? -LSTEP_W'(div_quot)
						                                 : LSTEP_W'(div_quot);
						state_q      <= S_FRQ_START;
					end
				end
				S_FRQ_START: begin
					state_q <= S_FRQ_WAIT;
				end
				S_FRQ_WAIT: begin
					if (div_done) begin
						frequency_step_q <= fdiff[FREQ_W+1] ? -FSTEP_W'(div_quot)
						                                    : FSTEP_W'(div_quot);
						state_q          <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					level_q     <= lv_next;
					frequency_q <= fq_next;
					state_q     <= S_MUL_AMP;
				end
				S_MUL_AMP: begin
					state_q <= S_MUL_PH;
				end
				S_MUL_PH: begin
					state_q <= S_PHASE;
				end
				S_PHASE: begin
					phase_q <= phase_q + mul_prod[PHASE_SHIFT +: PHASE_W];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Beat payload registers; a new sample is held until the output register frees.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			blk_n_q <= n_clamped;
			if (s_axis_tuser) begin
				tlevel_q <= tl_clamped;
				tfreq_q  <= tf_clamped;
			end
		end
		if (state_q == S_MUL_PH) begin
			sample_hold_q <= sample_next;
		end
		if ((state_q == S_OUT) && out_free) begin
			sample_q <= sample_hold_q;
		end
	end

endmodule

`default_nettype wire

// ----- bench/sine_oscillator_ramped_gain_freq_tb.sv -----
// Self-checking testbench for the ramped-gain, ramped-frequency sine oscillator.
`default_nettype none

module sine_oscillator_ramped_gain_freq_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sosc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE = 120;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint LEVEL_CEIL = 64'sh0000_0000_FFFF_FFFF;
	localparam longint FREQ_CEIL = (64'sd1 <<< FREQ_W) - 1;

	// Bit-true model of the oscillator together with the samples it still owes.
	class tone_model;
		int sine_table [SINE_DEPTH];
		logic [SCALE_W-1:0] scale;
		logic [PHASE_W-1:0] phase;
		logic [LEVEL_W-1:0] level;
		logic signed [LSTEP_W-1:0] level_step;
		logic [FREQ_W-1:0] freq;
		logic signed [FSTEP_W-1:0] freq_step;
		logic [SAMPLE_W-1:0] pending_samples [$];
		int mismatches;

		function new();
			for (int k = 0; k < SINE_DEPTH; k++) begin
				sine_table[k] = table_value(k);
			end
			scale = PHASE_SCALE_RESET;
			phase = '0;
			level = '0;
			level_step = '0;
			freq = '0;
			freq_step = '0;
			mismatches = 0;
		endfunction

		// Quarter-wave folded Taylor series in Q30, rounded to Q15.
		function int table_value(int k);
			longint unsigned divisors [5] = '{110, 72, 42, 20, 6};
			longint unsigned one, quad, r, x, x2, p, s, v;
			one = 64'd1 << 30;
			quad = (longint'(k) * 4) / SINE_DEPTH;
			r = (longint'(k) * 4) % SINE_DEPTH;
			if (quad[0]) begin
				r = SINE_DEPTH - r;
			end
			x = (r * HALF_PI_Q30) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			p = one;
			foreach (divisors[i]) begin
				p = one - ((x2 * p) >> 30) / divisors[i];
			end
			s = (x * p) >> 30;
			v = (s * 32767 + (one >> 1)) >> 30;
			if (v > 32767) begin
				v = 32767;
			end
			return (quad >= 2) ? -int'(v) : int'(v);
		endfunction

		// Advance the model by one accepted input beat and queue its sample.
		function void take_beat(input bit start, input logic [SAMPLES_W-1:0] samples,
				input logic [TLEVEL_W-1:0] tl_in, input logic [TFREQ_W-1:0] tf_in);
			longint n, tl, tf, lv, mag, fq, inc;
			int s;
			logic [SINE_ADDR_W-1:0] idx;
			if (start) begin
				n = longint'(samples);
				tl = longint'(tl_in);
				tf = longint'(tf_in);
				if (n < 1) begin
					n = 1;
				end
				if (n > BLOCK_MAX) begin
					n = BLOCK_MAX;
				end
				if (tl > LEVEL_TARGET_MAX) begin
					tl = LEVEL_TARGET_MAX;
				end
				if (tf > FREQ_TARGET_MAX) begin
					tf = FREQ_TARGET_MAX;
				end
				level_step = LSTEP_W'(((tl <<< FRAC_SHIFT) - longint'(level)) / n);
				freq_step = FSTEP_W'(((tf <<< FRAC_SHIFT) - longint'(freq)) / n);
			end

			// Gain ramp, clamped to stay inside its range.
			lv = longint'(level) + longint'(level_step);
			if (lv < 0) begin
				lv = 0;
			end
			if (lv > LEVEL_CEIL) begin
				lv = LEVEL_CEIL;
			end
			level = LEVEL_W'(lv);

			// Sine times gain, magnitude truncated and then saturated.
			idx = phase[PHASE_W-1 -: SINE_ADDR_W];
			s = sine_table[idx];
			mag = longint'((s < 0) ? -s : s);
			mag = (mag * longint'(level)) >>> 31;
			if (mag > 32768) begin
				mag = 32768;
			end
			if (s < 0) begin
				mag = -mag;
			end
			if (mag > 32767) begin
				mag = 32767;
			end
			pending_samples.push_back(SAMPLE_W'(mag));

			// Frequency ramp, then the phase step taken from the new frequency.
			fq = longint'(freq) + longint'(freq_step);
			if (fq < 0) begin
				fq = 0;
			end
			if (fq > FREQ_CEIL) begin
				fq = FREQ_CEIL;
			end
			freq = FREQ_W'(fq);
			inc = ((fq >>> FRAC_SHIFT) * longint'(scale)) >>> (48 - PHASE_W);
			phase = phase + PHASE_W'(inc);
		endfunction

		// Compare one output beat with the oldest sample still owed.
		function void check_sample(input logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			if (pending_samples.size() == 0) begin
				$error("sample_out: expected none, actual %0d", $signed(got));
				mismatches++;
				return;
			end
			want = pending_samples.pop_front();
			if (got !== want) begin
				$error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SCALE_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;
	bit calm = 1'b0;
	int unsigned cycle_count = 0;
	tone_model tones = new();

	always #10 clk = ~clk;

	sine_oscillator_ramped_gain_freq dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata)
	);

	// Output back-pressure: stall now and then, except in calm stretches.
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 7);
	end

	// Every output beat is checked as it is taken.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tones.check_sample(m_tdata);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sine_oscillator_ramped_gain_freq_tb: done, errors");
			$finish;
		end
	end

	// Offer one input beat, with an occasional gap first, and wait for it to be taken.
	task automatic send_beat(input bit start, input logic [SAMPLES_W-1:0] samples,
			input logic [TLEVEL_W-1:0] tl, input logic [TFREQ_W-1:0] tf);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= start;
		s_tdata <= IN_TDATA_W'({tf, tl, samples});
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		tones.take_beat(start, samples, tl, tf);
	endtask

	// Stop sending, let every owed sample arrive and the sequencer fall idle.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tones.pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tones.scale = value;
	endtask

	// Mostly block starts followed by a run of ticks, with some loose beats mixed in.
	task automatic random_phase(input int quota);
		int sent, roll, ticks;
		logic [SAMPLES_W-1:0] n;
		logic [TLEVEL_W-1:0] tl;
		logic [TFREQ_W-1:0] tf;
		sent = 0;
		while (sent < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < 82) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) begin
					n = SAMPLES_W'($urandom_range(1, 24));
				end else if (roll < 92) begin
					n = SAMPLES_W'($urandom_range(25, 400));
				end else begin
					n = SAMPLES_W'($urandom_range(0, 8191));
				end
				if ($urandom_range(0, 3) != 0) begin
					tl = TLEVEL_W'($urandom_range(0, LEVEL_TARGET_MAX));
				end else begin
					tl = TLEVEL_W'($urandom);
				end
				if ($urandom_range(0, 3) != 0) begin
					tf = TFREQ_W'($urandom_range(0, FREQ_TARGET_MAX));
				end else begin
					tf = TFREQ_W'($urandom);
				end
				send_beat(1'b1, n, tl, tf);
				sent++;
				ticks = $urandom_range(0, (n > 36) ? 40 : int'(n) + 4);
				repeat (ticks) begin
					send_beat(1'b0, SAMPLES_W'($urandom), TLEVEL_W'($urandom),
						TFREQ_W'($urandom));
					sent++;
				end
			end else begin
				send_beat(1'($urandom_range(0, 1)), SAMPLES_W'($urandom),
					TLEVEL_W'($urandom), TFREQ_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		logic [SCALE_W-1:0] scales [7];
		scales[0] = 28'd137438953;
		scales[1] = 28'd5726623;
		scales[2] = SCALE_W'($urandom_range(5726623, 137438953));
		scales[3] = '1;
		scales[4] = '0;
		scales[5] = PHASE_SCALE_RESET;
		scales[6] = SCALE_W'($urandom);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero block length with full-scale targets, then ticks that drive
		// gain and frequency into their upper saturation.
		send_beat(1'b1, 13'd0, 16'd32768, 21'd1280000);
		repeat (3) send_beat(1'b0, '1, '1, '1);
		// Targets and length above range are capped.
		send_beat(1'b1, 13'd8191, 16'hFFFF, 21'h1FFFFF);
		send_beat(1'b0, '0, '0, '0);
		// One-sample ramp to zero, then ticks that floor at zero.
		send_beat(1'b1, 13'd1, 16'd0, 21'd0);
		repeat (2) send_beat(1'b0, '0, '0, '0);
		// Longest block, and one just past it.
		send_beat(1'b1, 13'd4096, 16'd12345, 21'd112640);
		repeat (3) send_beat(1'b0, 13'h0AAA, 16'h5555, 21'h0AAAAA);
		send_beat(1'b1, 13'd4097, 16'd32767, 21'd1279999);
		send_beat(1'b0, 13'h1555, 16'hAAAA, 21'h155555);
		send_beat(1'b1, 13'd2, 16'h5555, 21'h0AAAAA);
		repeat (3) send_beat(1'b0, '0, '0, '0);
		send_beat(1'b1, 13'd3, 16'hAAAA, 21'h155555);
		repeat (2) send_beat(1'b0, '1, '1, '1);

		// Random traffic under a range of phase scales, one stretch without stalls.
		foreach (scales[i]) begin
			write_scale(scales[i]);
			calm = (i == 2);
			random_phase(120);
		end
		calm = 1'b0;

		wait_idle();
		if (tones.mismatches == 0) begin
			$display("sine_oscillator_ramped_gain_freq_tb: done, clean");
		end else begin
			$display("sine_oscillator_ramped_gain_freq_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
